@@ design/mbte_pkg.sv @@
// ----------------------------------------------------------------------------
// mbte_pkg: shared types and constants for the memory bank timing encoder
// Item structs, control word field positions, code tables and helpers.
// ----------------------------------------------------------------------------
package mbte_pkg;

  // width of a time value in tenths of a ns
  localparam int TIME_W     = 16;
  // number of timings in one item
  localparam int NUM_T      = 5;
  // largest access cycle count that still has a code
  localparam int MAX_ACC    = 14;
  // cells in the threshold chain: thresholds 0 .. MAX_ACC periods
  localparam int NUM_CELLS  = MAX_ACC + 1;
  localparam int CNT_W      = $clog2(NUM_CELLS + 1);
  // running multiple of the period, up to NUM_CELLS periods
  localparam int MULT_W     = TIME_W + $clog2(NUM_CELLS + 1);

  // timing slots inside the item
  localparam int T_ADDR_SETUP = 0;
  localparam int T_CS_SETUP   = 1;
  localparam int T_ACCESS     = 2;
  localparam int T_CS_HOLD    = 3;
  localparam int T_ADDR_HOLD  = 4;

  // field positions in the bank control word
  localparam int POS_ADDR_SETUP = 13;
  localparam int POS_CS_SETUP   = 11;
  localparam int POS_ACCESS     = 8;
  localparam int POS_CS_HOLD    = 6;
  localparam int POS_ADDR_HOLD  = 4;

  localparam logic [15:0] CLOCK_PERIOD_RST = 16'd100;
  localparam logic [31:0] KEEP_MASK_RST    = 32'h0001_8003;

  // configuration register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_CLOCK_PERIOD = 1'b0,
    REG_KEEP_MASK    = 1'b1
  } reg_idx_e;

  // item operation
  typedef enum logic [0:0] {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  // cycles per access code
  localparam logic [3:0] ACCESS_CYCLES [8] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd9, 4'd10, 4'd14
  };

  typedef struct packed {
    logic              action;
    logic [31:0]       control_in;
    logic [TIME_W-1:0] addr_setup_time;
    logic [TIME_W-1:0] cs_setup_time;
    logic [TIME_W-1:0] access_time;
    logic [TIME_W-1:0] cs_hold_time;
    logic [TIME_W-1:0] addr_hold_time;
    logic              wait_enable;
  } in_item_t;

  typedef struct packed {
    logic [31:0] control_out;
    logic        range_error;
    logic [17:0] addr_setup_out;
    logic [17:0] cs_setup_out;
    logic [19:0] access_out;
    logic [17:0] cs_hold_out;
    logic [17:0] addr_hold_out;
  } out_item_t;

  // item as it travels along the cell chain
  typedef struct packed {
    logic                         action;
    logic [31:0]                  control;
    logic                         wait_enable;
    logic [NUM_T-1:0][TIME_W-1:0] times;
    logic [NUM_T-1:0][CNT_W-1:0]  counts;
    logic [MULT_W-1:0]            mult;
  } cell_item_t;

  // two-bit field: {error, code}
  function automatic logic [2:0] short_code(input logic [CNT_W-1:0] n);
    logic       err;
    logic [1:0] code;
    err  = (n > CNT_W'(4));
    code = (n >= CNT_W'(3)) ? 2'd3 : n[1:0];
    return {err, code};
  endfunction

  // access field: {error, code}
  function automatic logic [3:0] access_code(input logic [CNT_W-1:0] n_in,
                                             input logic wait_en);
    logic [CNT_W-1:0] n;
    logic [2:0]       code;
    logic             err;
    n    = (wait_en && n_in < CNT_W'(4)) ? CNT_W'(4) : n_in;
    err  = 1'b0;
    code = 3'd0;
    if (n == '0) begin
      code = 3'd0;
    end else if (n <= CNT_W'(4)) begin
      code = 3'(n - CNT_W'(1));
    end else if (n <= CNT_W'(6)) begin
      code = 3'd4;
    end else if (n <= CNT_W'(8)) begin
      code = 3'd5;
    end else if (n <= CNT_W'(10)) begin
      code = 3'd6;
    end else if (n <= CNT_W'(MAX_ACC)) begin
      code = 3'd7;
    end else begin
      err = 1'b1;
    end
    return {err, code};
  endfunction

  // cycles for a two-bit code: 0, 1, 2, 4
  function automatic logic [2:0] short_cycles(input logic [1:0] c);
    return (c == 2'd3) ? 3'd4 : {1'b0, c};
  endfunction

endpackage

@@ design/mbte_cell.sv @@
// ----------------------------------------------------------------------------
// mbte_cell: one threshold cell of the ceiling-division chain
// Counts every timing that exceeds the current multiple of the period and
// hands the next multiple to its neighbor.
// ----------------------------------------------------------------------------
module mbte_cell import mbte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TIME_W-1:0] period_i,
  input  logic              valid_i,
  input  cell_item_t        item_i,
  output logic              ready_o,
  output logic              valid_o,
  output cell_item_t        item_o,
  input  logic              ready_i
);

  logic       valid_q;
  cell_item_t item_q, item_d;

  // stage takes an item when empty or when its item moves on
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // compare each timing with the threshold, step the threshold
  always_comb begin
    item_d = item_i;
    for (int t = 0; t < NUM_T; t++) begin
      if (MULT_W'(item_i.times[t]) > item_i.mult) begin
        item_d.counts[t] = item_i.counts[t] + CNT_W'(1);
      end
    end
    item_d.mult = item_i.mult + MULT_W'(period_i);
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

@@ design/mbte_out.sv @@
// ----------------------------------------------------------------------------
// mbte_out: code mapping, word packing, decode and output register
// Turns cycle counts into field codes or field codes into times and holds
// the result item until the receiver takes it.
// ----------------------------------------------------------------------------
module mbte_out import mbte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TIME_W-1:0] period_i,
  input  logic [31:0]       keep_mask_i,
  input  logic              valid_i,
  input  cell_item_t        item_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output out_item_t         out_item_o,
  input  logic              out_stall_i
);

  logic      valid_q;
  out_item_t item_q, item_d;

  logic [2:0]  c_as, c_cs, c_ch, c_ah;
  logic [3:0]  c_acc;
  logic        enc_err;
  logic [31:0] enc_word;
  logic [1:0]  d_as, d_cs, d_ch, d_ah;
  logic [2:0]  d_acc;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // encode: codes and packed word
  always_comb begin
    c_as  = short_code(item_i.counts[T_ADDR_SETUP]);
    c_cs  = short_code(item_i.counts[T_CS_SETUP]);
    c_ch  = short_code(item_i.counts[T_CS_HOLD]);
    c_ah  = short_code(item_i.counts[T_ADDR_HOLD]);
    c_acc = access_code(item_i.counts[T_ACCESS], item_i.wait_enable);
    enc_err = c_as[2] | c_cs[2] | c_ch[2] | c_ah[2] | c_acc[3];
    enc_word = (item_i.control & keep_mask_i)
             | (32'(c_as[1:0]) << POS_ADDR_SETUP)
             | (32'(c_cs[1:0]) << POS_CS_SETUP)
             | (32'(c_acc[2:0]) << POS_ACCESS)
             | (32'(c_ch[1:0]) << POS_CS_HOLD)
             | (32'(c_ah[1:0]) << POS_ADDR_HOLD);
  end

  // decode fields of the word
  assign d_as  = item_i.control[POS_ADDR_SETUP +: 2];
  assign d_cs  = item_i.control[POS_CS_SETUP +: 2];
  assign d_acc = item_i.control[POS_ACCESS +: 3];
  assign d_ch  = item_i.control[POS_CS_HOLD +: 2];
  assign d_ah  = item_i.control[POS_ADDR_HOLD +: 2];

  // result item
  always_comb begin
    item_d = '0;
    unique case (action_e'(item_i.action))
      ACT_DECODE: begin
        item_d.control_out    = item_i.control;
        item_d.addr_setup_out = 18'(period_i) * 18'(short_cycles(d_as));
        item_d.cs_setup_out   = 18'(period_i) * 18'(short_cycles(d_cs));
        item_d.access_out     = 20'(period_i) * 20'(ACCESS_CYCLES[d_acc]);
        item_d.cs_hold_out    = 18'(period_i) * 18'(short_cycles(d_ch));
        item_d.addr_hold_out  = 18'(period_i) * 18'(short_cycles(d_ah));
      end
      ACT_ENCODE: begin
        item_d.range_error = enc_err;
        item_d.control_out = enc_err ? item_i.control : enc_word;
      end
      default: item_d = '0;
    endcase
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

@@ design/memory_bank_timing_encoder_core.sv @@
// ----------------------------------------------------------------------------
// memory_bank_timing_encoder_core: bank timing encoder / decoder
// Converts static-memory bank timings between tenths of a ns and the packed
// bank control word, using the configured bus clock period.
//
// Usage:
//   Input channel in_valid_i / in_item_i / in_stall_o carries one item:
//   an action (encode or decode), the old control word, five timings and
//   the wait-enable flag. Output channel out_valid_o / out_item_o /
//   out_stall_i returns exactly one result item per input item, in order.
//   Each timing is turned into a cycle count by a chain of 15 cells; cell k
//   compares every timing against k times the clock period, so the count is built
//   while the item walks down the chain of cells and the output register.
//   One item is taken every cycle while in_stall_o is low. The user must
//   write clock_period (address 0) and keep_mask (address 4) through the
//   APB port only while the block is idle; the block does not enforce it.
//   Reset empties the chain and output register and loads the register
//   reset values. When the receiver stalls, the held result stays put and
//   the chain keeps filling its empty stages before in_stall_o rises.
// ----------------------------------------------------------------------------
module memory_bank_timing_encoder_core import mbte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  logic        out_stall_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]       clock_period_q;
  logic [31:0]       keep_mask_q;
  logic [TIME_W-1:0] period_eff;
  logic              cfg_wr;

  logic       cell_valid [NUM_CELLS+1];
  logic       cell_ready [NUM_CELLS+1];
  cell_item_t cell_item  [NUM_CELLS+1];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_period_q <= CLOCK_PERIOD_RST;
      keep_mask_q    <= KEEP_MASK_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_CLOCK_PERIOD: clock_period_q <= pwdata[15:0];
        REG_KEEP_MASK:    keep_mask_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_CLOCK_PERIOD: prdata = {16'b0, clock_period_q};
      REG_KEEP_MASK:    prdata = keep_mask_q;
      default:          prdata = '0;
    endcase
  end

  // encode treats a zero period as one
  assign period_eff = (clock_period_q == '0) ? TIME_W'(1) : clock_period_q;

  // chain entry
  assign cell_valid[0] = in_valid_i;
  assign in_stall_o    = !cell_ready[0];

  always_comb begin
    cell_item[0]             = '0;
    cell_item[0].action      = in_item_i.action;
    cell_item[0].control     = in_item_i.control_in;
    cell_item[0].wait_enable = in_item_i.wait_enable;
    cell_item[0].times[T_ADDR_SETUP] = in_item_i.addr_setup_time;
    cell_item[0].times[T_CS_SETUP]   = in_item_i.cs_setup_time;
    cell_item[0].times[T_ACCESS]     = in_item_i.access_time;
    cell_item[0].times[T_CS_HOLD]    = in_item_i.cs_hold_time;
    cell_item[0].times[T_ADDR_HOLD]  = in_item_i.addr_hold_time;
  end

  // threshold cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mbte_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .period_i (period_eff),
      .valid_i  (cell_valid[k]),
      .item_i   (cell_item[k]),
      .ready_o  (cell_ready[k]),
      .valid_o  (cell_valid[k+1]),
      .item_o   (cell_item[k+1]),
      .ready_i  (cell_ready[k+1])
    );
  end

  // codes, decode and output register
  mbte_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (clock_period_q),
    .keep_mask_i (keep_mask_q),
    .valid_i     (cell_valid[NUM_CELLS]),
    .item_i      (cell_item[NUM_CELLS]),
    .ready_o     (cell_ready[NUM_CELLS]),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  // an error result carries no decoded times
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.range_error |->
      out_item_o.access_out == '0 && out_item_o.addr_setup_out == '0 &&
      out_item_o.cs_hold_out == '0)
    else $error("range error with nonzero decoded time");

  // the last cell hands its item to the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[NUM_CELLS] && cell_ready[NUM_CELLS] |=> out_valid_o)
    else $error("item lost between chain and output register");

  // the chain only stalls the sender when the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

endmodule

@@ sim/tb_memory_bank_timing_encoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_memory_bank_timing_encoder_core: self-checking bench for the bank timing
// encoder. A short directed table, then random encode and decode items over
// several clock periods and keep masks. Each result is checked field by field
// against a fixed result or a predictor, with random bursts on the sender,
// stall patterns on the receiver, and APB register writes with read-back.
// ----------------------------------------------------------------------------
module tb_memory_bank_timing_encoder_core;
  import mbte_pkg::*;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 144;
  localparam int unsigned HOLD_CYCLES  = 96;
  localparam bit          TYPED        = 1'b1;
  localparam bit          PRED         = 1'b0;
  localparam int unsigned ACC_CYC [8]  = '{1, 2, 3, 4, 6, 9, 10, 14};

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FLOW, RX_COIN, RX_EVERY_THIRD, RX_SPARSE
  } rx_mode_e;

  typedef struct {
    logic [15:0] period;
    logic [31:0] mask;
    in_item_t    stim;
    bit          fixed;
    out_item_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  in_item_t    in_item;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_result;
  logic        out_stall;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // configuration as the block should hold it
  logic [15:0] cfg_period = CLOCK_PERIOD_RST;
  logic [31:0] cfg_mask   = KEEP_MASK_RST;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;

  memory_bank_timing_encoder_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_item_o  (out_result),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_memory_bank_timing_encoder_core NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned cycles_of_time(logic [15:0] t);
    int unsigned p;
    p = (cfg_period == '0) ? 1 : int'(cfg_period);
    if (t == '0) return 0;
    return (int'(t) - 1) / p + 1;
  endfunction

  // two-bit code back to cycles: 3 stands for 4
  function automatic int unsigned code_cycles(logic [1:0] c);
    return (c == 2'd3) ? 4 : int'(c);
  endfunction

  function automatic out_item_t bank_timing_result(in_item_t it);
    out_item_t   r;
    logic [15:0] st [4];
    logic [1:0]  sc [4];
    int unsigned n;
    logic [2:0]  ac;
    logic        err;
    logic [31:0] w;
    r = '0;
    if (it.action == ACT_DECODE) begin
      r.control_out    = it.control_in;
      r.addr_setup_out = 18'(cfg_period * code_cycles(it.control_in[14:13]));
      r.cs_setup_out   = 18'(cfg_period * code_cycles(it.control_in[12:11]));
      r.access_out     = 20'(cfg_period * ACC_CYC[it.control_in[10:8]]);
      r.cs_hold_out    = 18'(cfg_period * code_cycles(it.control_in[7:6]));
      r.addr_hold_out  = 18'(cfg_period * code_cycles(it.control_in[5:4]));
      return r;
    end
    st[0] = it.addr_setup_time;
    st[1] = it.cs_setup_time;
    st[2] = it.cs_hold_time;
    st[3] = it.addr_hold_time;
    err = 1'b0;
    for (int k = 0; k < 4; k++) begin
      n = cycles_of_time(st[k]);
      if (n > 4) err = 1'b1;
      sc[k] = (n >= 3) ? 2'd3 : 2'(n);
    end
    // access count, raised to at least four under external wait
    n = cycles_of_time(it.access_time);
    if (it.wait_enable && n < 4) n = 4;
    if (n > 14) err = 1'b1;
    if (n == 0) ac = 3'd0;
    else if (n <= 4) ac = 3'(n - 1);
    else if (n <= 6) ac = 3'd4;
    else if (n <= 8) ac = 3'd5;
    else if (n <= 10) ac = 3'd6;
    else ac = 3'd7;
    if (err) begin
      r.control_out = it.control_in;
      r.range_error = 1'b1;
    end else begin
      w = it.control_in & cfg_mask;
      w |= 32'(sc[0]) << POS_ADDR_SETUP;
      w |= 32'(sc[1]) << POS_CS_SETUP;
      w |= 32'(ac) << POS_ACCESS;
      w |= 32'(sc[2]) << POS_CS_HOLD;
      w |= 32'(sc[3]) << POS_ADDR_HOLD;
      r.control_out = w;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      note_mismatch("unexpected item control_out", '0, got.control_out);
      return;
    end
    want = pending_results.pop_front();
    if (want.control_out !== got.control_out)
      note_mismatch("control_out", want.control_out, got.control_out);
    if (want.range_error !== got.range_error)
      note_mismatch("range_error", want.range_error, got.range_error);
    if (want.addr_setup_out !== got.addr_setup_out)
      note_mismatch("addr_setup_out", want.addr_setup_out, got.addr_setup_out);
    if (want.cs_setup_out !== got.cs_setup_out)
      note_mismatch("cs_setup_out", want.cs_setup_out, got.cs_setup_out);
    if (want.access_out !== got.access_out)
      note_mismatch("access_out", want.access_out, got.access_out);
    if (want.cs_hold_out !== got.cs_hold_out)
      note_mismatch("cs_hold_out", want.cs_hold_out, got.cs_hold_out);
    if (want.addr_hold_out !== got.addr_hold_out)
      note_mismatch("addr_hold_out", want.addr_hold_out, got.addr_hold_out);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_result);
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    out_stall <= 1'b0;
    mode      = RX_FLOW;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          RX_FLOW:        out_stall <= 1'b0;
          RX_COIN:        out_stall <= 1'($urandom_range(0, 1));
          RX_EVERY_THIRD: out_stall <= (tick % 3 == 0);
          default:        out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_item(in_item_t it, out_item_t want);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
  endtask

  // one APB transfer, after which the bus is left idle
  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait for the block to drain, then write and read back both registers
  task automatic set_config(logic [15:0] period, logic [31:0] mask);
    logic [31:0] rd;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    apb_xfer(1'b1, REG_CLOCK_PERIOD, {16'h0, period}, rd);
    apb_xfer(1'b1, REG_KEEP_MASK, mask, rd);
    cfg_period = period;
    cfg_mask   = mask;
    apb_xfer(1'b0, REG_CLOCK_PERIOD, '0, rd);
    if (rd[15:0] !== period) note_mismatch("clock_period read", period, rd[15:0]);
    apb_xfer(1'b0, REG_KEEP_MASK, '0, rd);
    if (rd !== mask) note_mismatch("keep_mask read", mask, rd);
  endtask

  function automatic in_item_t timing_item(action_e act, logic [31:0] ctl,
                                           logic [15:0] as_t, logic [15:0] cs_t,
                                           logic [15:0] acc_t, logic [15:0] ch_t,
                                           logic [15:0] ah_t, logic we);
    return '{act, ctl, as_t, cs_t, acc_t, ch_t, ah_t, we};
  endfunction

  function automatic out_item_t fixed_result(logic [31:0] co, logic re, logic [17:0] as_o,
                                             logic [17:0] cs_o, logic [19:0] acc_o,
                                             logic [17:0] ch_o, logic [17:0] ah_o);
    return '{co, re, as_o, cs_o, acc_o, ch_o, ah_o};
  endfunction

  task automatic add_row(logic [15:0] period, logic [31:0] mask, in_item_t stim, bit fixed,
                         out_item_t want);
    dir_rows.push_back('{period, mask, stim, fixed, want});
  endtask

  // a time that needs cnt cycles at the current period, saturated to 16 bits
  function automatic logic [15:0] time_for_count(int unsigned cnt);
    int unsigned p;
    int unsigned lo;
    int unsigned hi;
    p = (cfg_period == '0) ? 1 : int'(cfg_period);
    if (cnt == 0) return '0;
    lo = (cnt - 1) * p + 1;
    hi = cnt * p;
    if (lo > 65535) return 16'hFFFF;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 3))
      0:       return 16'(lo);
      1:       return 16'(hi);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // cycle count for a two-bit field, now and then out of range
  function automatic int unsigned short_count();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
  endfunction

  function automatic in_item_t random_timing_item();
    in_item_t it;
    it.action      = ($urandom_range(0, 9) < 3) ? ACT_DECODE : ACT_ENCODE;
    it.control_in  = $urandom;
    it.wait_enable = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8) begin
      it.addr_setup_time = time_for_count(short_count());
      it.cs_setup_time   = time_for_count(short_count());
      it.cs_hold_time    = time_for_count(short_count());
      it.addr_hold_time  = time_for_count(short_count());
      it.access_time     = time_for_count(($urandom_range(0, 24) == 0) ?
                                          $urandom_range(15, 17) : $urandom_range(0, 14));
    end else begin
      it.addr_setup_time = 16'($urandom);
      it.cs_setup_time   = 16'($urandom);
      it.access_time     = 16'($urandom);
      it.cs_hold_time    = 16'($urandom);
      it.addr_hold_time  = 16'($urandom);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    logic [15:0] ph_period [NUM_PHASES];
    logic [31:0] ph_mask [NUM_PHASES];
    in_item_t    it;
    out_item_t   want;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned no_gap_left;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: reset configuration
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0),
            TYPED, fixed_result(32'h0001_8003, 1'b0, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0, 1, 101, 1, 201, 301, 1'b0), PRED, '0);
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0, 400, 400, 1400, 400, 400, 1'b0),
            TYPED, fixed_result(32'h0000_7FF0, 1'b0, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b1),
            TYPED, fixed_result(32'h1234_5678, 1'b1, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'hA5A5_A5A5, 0, 0, 1401, 0, 0, 1'b0),
            TYPED, fixed_result(32'hA5A5_A5A5, 1'b1, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0F0F_0F0F, 401, 0, 0, 0, 0, 1'b0),
            TYPED, fixed_result(32'h0F0F_0F0F, 1'b1, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'hF0F0_F0F0, 0, 401, 0, 0, 0, 1'b0),
            TYPED, fixed_result(32'hF0F0_F0F0, 1'b1, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h5555_5555, 0, 0, 0, 401, 0, 1'b0),
            TYPED, fixed_result(32'h5555_5555, 1'b1, 0, 0, 0, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'hAAAA_AAAA, 0, 0, 0, 0, 401, 1'b0),
            TYPED, fixed_result(32'hAAAA_AAAA, 1'b1, 0, 0, 0, 0, 0));
    // external wait raises short access counts
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0, 0, 0, 0, 0, 0, 1'b1), PRED, '0);
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0, 0, 0, 150, 0, 0, 1'b1), PRED, '0);
    // access bands
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'hFFFF_0000, 0, 0, 501, 0, 0, 1'b0), PRED, '0);
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0000_FFFF, 0, 0, 700, 0, 0, 1'b0), PRED, '0);
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h0001_0002, 0, 0, 900, 0, 0, 1'b0), PRED, '0);
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_ENCODE, 32'h8000_0001, 0, 0, 1100, 0, 0, 1'b1), PRED, '0);
    // decode, times and wait ignored
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_DECODE, 32'h0, 0, 0, 0, 0, 0, 1'b0),
            TYPED, fixed_result(32'h0, 1'b0, 0, 0, 100, 0, 0));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_DECODE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b1),
            TYPED, fixed_result(32'hFFFF_FFFF, 1'b0, 400, 400, 1400, 400, 400));
    add_row(CLOCK_PERIOD_RST, KEEP_MASK_RST,
            timing_item(ACT_DECODE, 32'h0000_5A50, 0, 0, 0, 0, 0, 1'b0), PRED, '0);
    // zero clock period
    add_row(16'd0, 32'h0,
            timing_item(ACT_DECODE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0),
            TYPED, fixed_result(32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0, 0));
    add_row(16'd0, 32'h0,
            timing_item(ACT_ENCODE, 32'hFFFF_FFFF, 3, 2, 14, 1, 0, 1'b0), PRED, '0);
    add_row(16'd0, 32'h0,
            timing_item(ACT_ENCODE, 32'h0BAD_CAFE, 0, 0, 15, 0, 0, 1'b0),
            TYPED, fixed_result(32'h0BAD_CAFE, 1'b1, 0, 0, 0, 0, 0));
    // largest clock period
    add_row(16'hFFFF, 32'hFFFF_FFFF,
            timing_item(ACT_DECODE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0),
            TYPED, fixed_result(32'hFFFF_FFFF, 1'b0, 262140, 262140, 917490, 262140, 262140));
    add_row(16'hFFFF, 32'hFFFF_FFFF,
            timing_item(ACT_ENCODE, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        1'b1), PRED, '0);
    add_row(16'hFFFF, 32'hFFFF_FFFF,
            timing_item(ACT_ENCODE, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1'b0), PRED, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].period != cfg_period || dir_rows[i].mask != cfg_mask)
        set_config(dir_rows[i].period, dir_rows[i].mask);
      want = dir_rows[i].fixed ? dir_rows[i].want : bank_timing_result(dir_rows[i].stim);
      send_item(dir_rows[i].stim, want);
    end

    // random phases: extremes first, then random settings
    ph_period[0] = 16'd1;          ph_mask[0] = 32'h0;
    ph_period[1] = 16'hFFFF;       ph_mask[1] = 32'hFFFF_FFFF;
    ph_period[2] = 16'd0;          ph_mask[2] = $urandom;
    ph_period[3] = 16'd3;          ph_mask[3] = KEEP_MASK_RST;
    for (int p = 4; p < NUM_PHASES; p++) begin
      ph_period[p] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(1, 2000));
      ph_mask[p]   = $urandom;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(ph_period[p], ph_mask[p]);
      burst_left  = $urandom_range(1, 30);
      no_gap_left = 0;
      // long receiver hold while the sender keeps offering items
      if (p == 3) begin
        long_hold_req = 1'b1;
        no_gap_left   = 80;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        it = random_timing_item();
        send_item(it, bank_timing_result(it));
        if (no_gap_left > 0) begin
          no_gap_left--;
        end else if (p == 5 && i == PHASE_ITEMS / 2) begin
          // sender waits until every result has come back
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_results.size() != 0);
        end else if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12)
                                                   : $urandom_range(0, 4);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    // drain and let any stray item show up
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_memory_bank_timing_encoder_core OK");
    end else begin
      $display("tb_memory_bank_timing_encoder_core NOT OK");
    end
    $finish;
  end

endmodule
